FILE: rtl/text_console_cursor_scroll_core_macros.svh
// Assertion macros for the console core RTL.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH

`ifndef SYNTH

`define TCCS_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("tccs: implication check failed");

`define TCCS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("tccs: next-cycle check failed");

`else

`define TCCS_ASSERT_IMPLY(lbl, clk, rst_n, pre, post)

`define TCCS_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

FILE: rtl/tccs_pkg.sv
// Types and constants shared by the console core modules.
package tccs_pkg;

    localparam logic [7:0] CODE_NEWLINE    = 8'h0A;
    localparam logic [7:0] CODE_RETURN     = 8'h0D;
    localparam logic [7:0] CODE_BACKSPACE  = 8'h08;
    localparam logic [7:0] CODE_PRINT_LOW  = 8'd32;
    localparam logic [7:0] CODE_PRINT_END  = 8'd127;
    localparam logic [7:0] CODE_SPACE      = 8'h20;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACK,
        OP_IGNORE,
        OP_READ
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] code;
        logic [4:0] row;
        logic [6:0] col;
        logic       in_range;
    } t_op;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

    typedef enum logic [1:0] {
        BK_INIT,
        BK_IDLE,
        BK_READ,
        BK_CLEAR
    } t_back_state;

endpackage

FILE: rtl/tccs_front.sv
// Input side: accepts transfers and classifies each into a console operation.
module tccs_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tccs_pkg::t_in_item    i_in_item,
    input  tccs_pkg::t_back_stat  i_stat,
    input  logic                  i_q_full,
    output logic                  o_push,
    output tccs_pkg::t_op         o_op
);
    import tccs_pkg::*;

    localparam logic [8:0] ROWS_W = 9'(ROWS);
    localparam logic [8:0] COLS_W = 9'(COLUMNS);

    assign o_in_stall = i_q_full || i_stat.init_busy;
    assign o_push     = i_in_valid && !o_in_stall;

    always_comb begin
        o_op.code     = i_in_item.char_code;
        o_op.row      = i_in_item.read_row;
        o_op.col      = i_in_item.read_col;
        o_op.in_range = (9'(i_in_item.read_row) < ROWS_W) &&
                        (9'(i_in_item.read_col) < COLS_W);
        priority if (i_in_item.cmd == CMD_READ) begin
            o_op.kind = OP_READ;
        end else if (i_in_item.char_code == CODE_NEWLINE) begin
            o_op.kind = OP_NEWLINE;
        end else if (i_in_item.char_code == CODE_RETURN) begin
            o_op.kind = OP_RETURN;
        end else if (i_in_item.char_code == CODE_BACKSPACE) begin
            o_op.kind = OP_BACK;
        end else if (i_in_item.char_code >= CODE_PRINT_LOW &&
                     i_in_item.char_code < CODE_PRINT_END) begin
            o_op.kind = OP_PRINT;
        end else begin
            o_op.kind = OP_IGNORE;
        end
    end

endmodule

FILE: rtl/tccs_queue.sv
// Two-entry operation queue between the front and back parts.
module tccs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tccs_pkg::t_op  i_op,
    input  logic           i_pop,
    output tccs_pkg::t_op  o_head,
    output logic           o_not_empty,
    output logic           o_full
);
    import tccs_pkg::*;

    t_op                r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_PTR_W:0]   r_count;
    logic [Q_PTR_W-1:0] n_wptr;
    logic [Q_PTR_W-1:0] n_rptr;
    logic [Q_PTR_W:0]   n_count;
    logic               do_pop;

    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_head      = r_buf[r_rptr];
    assign do_pop      = i_pop && o_not_empty;

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_op;
        end
    end

endmodule

FILE: rtl/tccs_back.sv
// Execution side: cursor, rotating cell store, row clearing and result register.
`include "text_console_cursor_scroll_core_macros.svh"

module tccs_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tccs_pkg::t_op         i_head,
    input  logic                  i_head_valid,
    output logic                  o_pop,
    output tccs_pkg::t_back_stat  o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tccs_pkg::t_out_item   o_out_item
);
    import tccs_pkg::*;

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [RW:0]   ROWS_W   = (RW+1)'(ROWS);

    t_back_state   r_state, n_state;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [RW-1:0] r_cur_row, n_cur_row;
    logic [RW-1:0] r_top, n_top;
    logic [RW-1:0] r_clr_row, n_clr_row;
    logic [CW-1:0] r_clr_col, n_clr_col;
    logic          r_rd_hit, n_rd_hit;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic          out_free;
    logic          wrap_row;

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] row);
        logic [RW:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= ROWS_W) begin
            sum = sum - ROWS_W;
        end
        return sum[RW-1:0];
    endfunction

    assign out_free         = !r_out_valid || !i_out_stall;
    assign o_stat.init_busy = (r_state == BK_INIT);
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;
    assign rd_addr          = i_head.in_range ?
                              {phys_row(r_top, RW'(i_head.row)), CW'(i_head.col)} : '0;

    always_comb begin
        n_state     = r_state;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_top       = r_top;
        n_clr_row   = r_clr_row;
        n_clr_col   = r_clr_col;
        n_rd_hit    = r_rd_hit;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        wr_addr     = {r_clr_row, r_clr_col};
        wr_data     = CODE_SPACE;
        wrap_row    = 1'b0;

        unique case (r_state)
            BK_INIT: begin
                mem_we = 1'b1;
                if (r_clr_col == LAST_COL) begin
                    n_clr_col = '0;
                    if (r_clr_row == LAST_ROW) begin
                        n_clr_row = '0;
                        n_state   = BK_IDLE;
                    end else begin
                        n_clr_row = r_clr_row + 1'b1;
                    end
                end else begin
                    n_clr_col = r_clr_col + 1'b1;
                end
            end
            BK_IDLE: begin
                if (i_head_valid && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_head.kind)
                        OP_READ: begin
                            n_rd_hit = i_head.in_range;
                            n_state  = BK_READ;
                        end
                        OP_PRINT: begin
                            mem_we  = 1'b1;
                            wr_addr = {phys_row(r_top, r_cur_row), r_cur_col};
                            wr_data = i_head.code;
                            if (r_cur_col == LAST_COL) begin
                                n_cur_col = '0;
                                wrap_row  = 1'b1;
                            end else begin
                                n_cur_col = r_cur_col + 1'b1;
                            end
                        end
                        OP_NEWLINE: begin
                            n_cur_col = '0;
                            wrap_row  = 1'b1;
                        end
                        OP_RETURN: begin
                            n_cur_col = '0;
                        end
                        OP_BACK: begin
                            if (r_cur_col != '0) begin
                                n_cur_col = r_cur_col - 1'b1;
                            end
                        end
                        OP_IGNORE: begin
                        end
                        default: begin
                        end
                    endcase
                    if (i_head.kind != OP_READ) begin
                        if (wrap_row && r_cur_row == LAST_ROW) begin
                            n_top     = (r_top == LAST_ROW) ? '0 : r_top + 1'b1;
                            n_clr_row = r_top;
                            n_clr_col = '0;
                            n_state   = BK_CLEAR;
                        end else begin
                            if (wrap_row) begin
                                n_cur_row = r_cur_row + 1'b1;
                            end
                            n_out_valid      = 1'b1;
                            n_out.cell_char  = '0;
                            n_out.cursor_col = 7'(n_cur_col);
                            n_out.cursor_row = 5'(n_cur_row);
                            n_out.scrolled   = 1'b0;
                        end
                    end
                end
            end
            BK_READ: begin
                n_out_valid      = 1'b1;
                n_out.cell_char  = r_rd_hit ? r_rd_data : '0;
                n_out.cursor_col = 7'(r_cur_col);
                n_out.cursor_row = 5'(r_cur_row);
                n_out.scrolled   = 1'b0;
                n_state          = BK_IDLE;
            end
            BK_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_col == LAST_COL) begin
                    n_clr_col        = '0;
                    n_out_valid      = 1'b1;
                    n_out.cell_char  = '0;
                    n_out.cursor_col = 7'(r_cur_col);
                    n_out.cursor_row = 5'(r_cur_row);
                    n_out.scrolled   = 1'b1;
                    n_state          = BK_IDLE;
                end else begin
                    n_clr_col = r_clr_col + 1'b1;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_INIT;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_top       <= '0;
            r_clr_row   <= '0;
            r_clr_col   <= '0;
            r_rd_hit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_top       <= n_top;
            r_clr_row   <= n_clr_row;
            r_clr_col   <= n_clr_col;
            r_rd_hit    <= n_rd_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
    end

    `TCCS_ASSERT_IMPLY(a_cursor_range, i_clk, i_rst_n, 1'b1,
        r_cur_col <= LAST_COL && r_cur_row <= LAST_ROW && r_top <= LAST_ROW)
    `TCCS_ASSERT_NEXT(a_clear_result, i_clk, i_rst_n,
        r_state == BK_CLEAR && r_clr_col == LAST_COL, r_out_valid && r_out.scrolled)
    `TCCS_ASSERT_NEXT(a_read_result, i_clk, i_rst_n,
        r_state == BK_READ, r_out_valid && !r_out.scrolled)
    `TCCS_ASSERT_IMPLY(a_pop_when_free, i_clk, i_rst_n,
        o_pop, r_state == BK_IDLE && out_free)

endmodule

FILE: rtl/text_console_cursor_scroll_core.sv
// Text console core: cursor control, scrolling cell store and cell readback.
// A put item is executed in the back part's idle state once it reaches the queue head and the
// result register is free; a read also passes the BK_READ state in the back part because
// the cell store has a registered read port. A put that scrolls the screen clears the new bottom
// row one cell per cycle before its result appears. After reset the cell store is filled with
// spaces by a clearing pass over all ROWS*COLUMNS cells, during which o_in_stall stays high.
// Rows are mapped through a rotating top-row pointer, so a scroll moves no data.
// Cursor outputs carry the low bits of the cursor when COLUMNS or ROWS exceed the field widths.
module text_console_cursor_scroll_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tccs_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tccs_pkg::t_out_item  o_out_item
);
    import tccs_pkg::*;

    t_op        front_op;
    t_op        head_op;
    t_back_stat back_stat;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_not_empty;

    tccs_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_stat     (back_stat),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_op       (front_op)
    );

    tccs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (front_op),
        .i_pop       (pop),
        .o_head      (head_op),
        .o_not_empty (q_not_empty),
        .o_full      (q_full)
    );

    tccs_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_op),
        .i_head_valid (q_not_empty),
        .o_pop        (pop),
        .o_stat       (back_stat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule
